// ----- rtl/npcd_pkg.sv -----
// types, codes and crc helper shared by the nibble parity deframer
`timescale 1ns / 1ps
`default_nettype none

package npcd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h07;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ODD    = 2'd1,
        ST_PARITY = 2'd2,
        ST_CRC    = 2'd3
    } t_status;

    typedef struct packed {
        logic [4:0] line_symbol;
        logic       frame_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       frame_done;
        t_status    frame_status;
    } t_out_item;

    // result from the decode stage toward the output buffer
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res;

    // crc-8, msb first, one byte per call
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/npcd_core.sv -----
// symbol decode, byte assembly, crc tracking and frame status
`timescale 1ns / 1ps
`default_nettype none

module npcd_core
    import npcd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    input  wire logic     i_check_crc,
    output t_res          o_res
);

    logic       r_half_pending, n_half_pending;
    logic [3:0] r_high_nibble,  n_high_nibble;
    logic [7:0] r_held_byte,    n_held_byte;
    logic       r_held_valid,   n_held_valid;
    logic [7:0] r_running_crc,  n_running_crc;
    logic       r_perr_seen,    n_perr_seen;

    logic [3:0] nib;
    logic       bad_parity;
    logic       perr_now;
    logic [7:0] full_byte;
    logic [7:0] crc_after;
    logic       emit;
    logic [7:0] emit_byte;
    logic       done;
    t_status    status;

    assign nib        = i_item.line_symbol[3:0];
    assign bad_parity = i_item.line_symbol[4] ^ (^nib);
    assign perr_now   = r_perr_seen | bad_parity;
    assign full_byte  = {r_high_nibble, nib};
    assign crc_after  = (i_check_crc && r_held_valid) ?
                        crc8_byte(r_running_crc, r_held_byte) : r_running_crc;

    always_comb begin
        n_half_pending = r_half_pending;
        n_high_nibble  = r_high_nibble;
        n_held_byte    = r_held_byte;
        n_held_valid   = r_held_valid;
        n_running_crc  = r_running_crc;
        n_perr_seen    = r_perr_seen;
        emit           = 1'b0;
        emit_byte      = 8'h00;
        done           = 1'b0;
        status         = ST_OK;
        if (i_accept) begin
            n_perr_seen = perr_now;
            if (!r_half_pending) begin
                n_high_nibble  = nib;
                n_half_pending = 1'b1;
                if (i_item.frame_last) begin
                    done   = 1'b1;
                    status = ST_ODD;
                end
            end else begin
                n_half_pending = 1'b0;
                if (i_check_crc) begin
                    // hold back one byte, the last one is the crc
                    if (r_held_valid) begin
                        emit      = 1'b1;
                        emit_byte = r_held_byte;
                    end
                    n_running_crc = crc_after;
                    n_held_byte   = full_byte;
                    n_held_valid  = 1'b1;
                end else begin
                    n_held_valid = 1'b0;
                    emit         = 1'b1;
                    emit_byte    = full_byte;
                end
                if (i_item.frame_last) begin
                    done = 1'b1;
                    if (perr_now) begin
                        status = ST_PARITY;
                    end else if (i_check_crc && (full_byte != crc_after)) begin
                        status = ST_CRC;
                    end else begin
                        status = ST_OK;
                    end
                end
            end
            if (done) begin
                n_half_pending = 1'b0;
                n_high_nibble  = 4'h0;
                n_held_byte    = 8'h00;
                n_held_valid   = 1'b0;
                n_running_crc  = 8'h00;
                n_perr_seen    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_pending <= 1'b0;
            r_held_valid   <= 1'b0;
            r_running_crc  <= 8'h00;
            r_perr_seen    <= 1'b0;
        end else begin
            r_half_pending <= n_half_pending;
            r_held_valid   <= n_held_valid;
            r_running_crc  <= n_running_crc;
            r_perr_seen    <= n_perr_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_high_nibble <= n_high_nibble;
        r_held_byte   <= n_held_byte;
    end

    always_comb begin
        o_res.valid             = emit | done;
        o_res.item.data_byte    = emit_byte;
        o_res.item.byte_valid   = emit;
        o_res.item.frame_done   = done;
        o_res.item.frame_status = status;
    end

`ifndef SYNTHESIS
    // frame end leaves a clean slate
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.frame_last) |=>
            (!r_half_pending && !r_held_valid && (r_running_crc == 8'h00) && !r_perr_seen))
        else $error("frame state not cleared after frame end");

    // a high nibble that does not end the frame gives no result
    a_high_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !r_half_pending && !i_item.frame_last) |-> !o_res.valid)
        else $error("result on a lone high nibble");

    // odd symbol count never carries a byte
    a_odd_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.item.frame_status == ST_ODD) |->
            (!o_res.item.byte_valid && o_res.item.frame_done))
        else $error("odd count status with a byte");
`endif

endmodule

`default_nettype wire

// ----- rtl/npcd_obuf.sv -----
// output register with one skid entry so one more result can enter while output stalls
`timescale 1ns / 1ps
`default_nettype none

module npcd_obuf
    import npcd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_res i_res,
    input  wire logic i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    output logic      o_in_ready
);

    logic      r_out_valid,  n_out_valid;
    t_out_item r_out_item,   n_out_item;
    logic      r_skid_valid, n_skid_valid;
    t_out_item r_skid_item,  n_skid_item;
    logic      out_take;

    assign out_take = r_out_valid & i_out_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;
        n_skid_valid = r_skid_valid;
        n_skid_item  = r_skid_item;
        if (r_skid_valid) begin
            // input is held off while the skid entry is full
            if (out_take) begin
                n_out_item   = r_skid_item;
                n_skid_valid = 1'b0;
            end
        end else if (i_res.valid) begin
            if (!r_out_valid || out_take) begin
                n_out_item  = i_res.item;
                n_out_valid = 1'b1;
            end else begin
                n_skid_item  = i_res.item;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item  <= n_out_item;
        r_skid_item <= n_skid_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_in_ready  = ~r_skid_valid;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full with output register empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res.valid && !r_skid_valid && r_out_valid && !i_out_ready) |=> r_skid_valid)
        else $error("result lost while output stalled");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_ready) |=> (o_out_valid && !r_skid_valid))
        else $error("skid entry not moved to output");
`endif

endmodule

`default_nettype wire

// ----- rtl/nibble_parity_crc8_deframer_core.sv -----
// nibble parity deframer top level: config register, decode core, output buffer
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_item  (line_symbol, frame_last)
//  out     | output    | o_out_valid / i_out_ready | o_out_item (data_byte, byte_valid,
//          |           |                           |  frame_done, frame_status)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (check_crc)
//
// one item per cycle while o_in_ready is high; a result is registered in the output
// register, or in the skid entry while output stalls; parity, byte assembly and one crc-8
// byte update sit between the state and output registers; the skid entry takes one more
// result while output stalls, then o_in_ready stays low until the output register is read
// synchronous active-low reset clears frame state, buffer valids and check_crc
`timescale 1ns / 1ps
`default_nettype none

module nibble_parity_crc8_deframer_core
    import npcd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_data
);

    logic r_check_crc;
    logic in_accept;
    t_res core_res;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_crc <= 1'b0;
        end else if (i_cfg_valid) begin
            r_check_crc <= i_cfg_data;
        end
    end

    npcd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in_item),
        .i_check_crc (r_check_crc),
        .o_res       (core_res)
    );

    npcd_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (core_res),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_in_ready  (o_in_ready)
    );

endmodule

`default_nettype wire
